[hw/rtl/mco_pkg.sv]
// Shared types, constants and width helpers for the midpoint circle outline block.
// No dependencies; all files in hw/rtl but mco_queue refer to it by scoped names.
package mco_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF = 14;
  localparam int MAX_RADIUS_DEF = 4095;

  // Fixed field widths
  localparam int RADIUS_W  = 12;
  localparam int COLOR_W   = 32;
  localparam int ADDR_W    = 26;
  localparam int PITCH_W   = 15;
  localparam int PBYTES_W  = 3;
  localparam int CANVAS_W  = 13;
  localparam int USER_W    = 3;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_ROW_PITCH     = 2'd0;
  localparam logic [1:0] REG_PIXEL_BYTES   = 2'd1;
  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd2;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd3;

  // Register reset values
  localparam logic [PITCH_W-1:0]  ROW_PITCH_RST   = 15'd4096;
  localparam logic [PBYTES_W-1:0] PIXEL_BYTES_RST = 3'd4;
  localparam logic [CANVAS_W-1:0] CANVAS_RST      = 13'd1024;

  // Result flag positions in tuser
  localparam int USER_VALID = 0;
  localparam int USER_INB   = 1;
  localparam int USER_FIN   = 2;

  // Index of the last octant write of a step
  localparam logic [2:0] OCT_LAST = 3'd7;

  // Configuration seen by the back end
  typedef struct packed {
    logic [PITCH_W-1:0]  row_pitch;
    logic [PBYTES_W-1:0] pixel_bytes;
    logic [CANVAS_W-1:0] canvas_width;
    logic [CANVAS_W-1:0] canvas_height;
  } cfg_t;

  // Bits needed for a walk coordinate
  function automatic int radius_bits(input int max_radius);
    radius_bits = $clog2(max_radius + 1);
  endfunction

  // Job word: finish flag, centre column, centre row, colour, walk X, walk Y
  function automatic int job_width(input int coord_bits, input int rad_bits);
    job_width = 1 + 2 * coord_bits + COLOR_W + 2 * rad_bits;
  endfunction

endpackage

[hw/rtl/mco_queue.sv]
// Small register queue that decouples the front end from the back end.
// Depends on nothing but its parameters; depth of two or more.
module mco_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/mco_front.sv]
// Front end: accepts start and step items, keeps the walk state and queues one job per step.
// Depends on mco_pkg.
module mco_front #(
  parameter int COORD_BITS = mco_pkg::COORD_BITS_DEF,
  parameter int MAX_RADIUS = mco_pkg::MAX_RADIUS_DEF,
  localparam int RB = mco_pkg::radius_bits(MAX_RADIUS),
  localparam int JW = mco_pkg::job_width(COORD_BITS, RB)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [COORD_BITS-1:0]        center_x_i,
  input  logic [COORD_BITS-1:0]        center_y_i,
  input  logic [mco_pkg::RADIUS_W-1:0] radius_i,
  input  logic [mco_pkg::COLOR_W-1:0]  color_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output logic [JW-1:0]                job_o
);

  localparam int EW = RB + 4;
  localparam int SW = (RB > mco_pkg::RADIUS_W) ? RB : mco_pkg::RADIUS_W;
  localparam logic [SW-1:0] RAD_MAX = SW'(MAX_RADIUS);
  localparam logic signed [EW-1:0] ERR_TWO   = EW'(2);
  localparam logic signed [EW-1:0] ERR_THREE = EW'(3);

  logic [COORD_BITS-1:0]       centre_col_q, centre_col_d;
  logic [COORD_BITS-1:0]       centre_row_q, centre_row_d;
  logic [mco_pkg::COLOR_W-1:0] draw_color_q, draw_color_d;
  logic [RB-1:0]               walk_x_q, walk_x_d;
  logic [RB-1:0]               walk_y_q, walk_y_d;
  logic signed [EW-1:0]        err_q, err_d;
  logic                        busy_q, busy_d;

  logic                 accept, walk_on;
  logic [SW-1:0]        rad_ext, rad_sat;
  logic signed [EW-1:0] y_twice, x_twice, err_a, err_b;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign walk_on    = busy_q && (walk_x_q > walk_y_q);

  // Clamp the radius
  assign rad_ext = SW'(radius_i);
  assign rad_sat = (rad_ext > RAD_MAX) ? RAD_MAX : rad_ext;

  // Decision term after one step
  assign y_twice = $signed(EW'({walk_y_q, 1'b0}));
  assign x_twice = $signed(EW'({walk_x_q, 1'b0}));
  assign err_a   = err_q + y_twice + ERR_TWO;
  assign err_b   = err_a - x_twice + ERR_THREE;

  // Classify the item; for a step, queue a job and advance the walk
  always_comb begin
    centre_col_d = centre_col_q;
    centre_row_d = centre_row_q;
    draw_color_d = draw_color_q;
    walk_x_d     = walk_x_q;
    walk_y_d     = walk_y_q;
    err_d        = err_q;
    busy_d       = busy_q;
    job_valid_o  = 1'b0;
    job_o        = {1'b1, {(JW-1){1'b0}}};
    if (accept) begin
      if (req_type_i == mco_pkg::REQ_START) begin
        centre_col_d = center_x_i;
        centre_row_d = center_y_i;
        draw_color_d = color_i;
        walk_x_d     = RB'(rad_sat);
        walk_y_d     = '0;
        err_d        = -$signed(EW'(RB'(rad_sat)));
        busy_d       = 1'b1;
      end else begin
        job_valid_o = 1'b1;
        if (walk_on) begin
          job_o    = {1'b0, centre_col_q, centre_row_q, draw_color_q, walk_x_q, walk_y_q};
          walk_y_d = walk_y_q + RB'(1);
          if (!err_a[EW-1]) begin
            walk_x_d = walk_x_q - RB'(1);
            err_d    = err_b;
          end else begin
            err_d    = err_a;
          end
        end else begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_col_q <= '0;
      centre_row_q <= '0;
      draw_color_q <= '0;
      walk_x_q     <= '0;
      walk_y_q     <= '0;
      err_q        <= '0;
      busy_q       <= 1'b0;
    end else begin
      centre_col_q <= centre_col_d;
      centre_row_q <= centre_row_d;
      draw_color_q <= draw_color_d;
      walk_x_q     <= walk_x_d;
      walk_y_q     <= walk_y_d;
      err_q        <= err_d;
      busy_q       <= busy_d;
    end
  end

endmodule

[hw/rtl/mco_back.sv]
// Back end: expands each queued job into eight octant writes or one finished result.
// Three stages (coordinates, bounds and products, address); depends on mco_pkg.
module mco_back #(
  parameter int COORD_BITS = mco_pkg::COORD_BITS_DEF,
  parameter int MAX_RADIUS = mco_pkg::MAX_RADIUS_DEF,
  localparam int RB = mco_pkg::radius_bits(MAX_RADIUS),
  localparam int JW = mco_pkg::job_width(COORD_BITS, RB)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  logic [JW-1:0]               job_i,
  output logic                        job_pop_o,
  input  mco_pkg::cfg_t               cfg_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [COORD_BITS:0]         pixel_x_o,
  output logic [COORD_BITS:0]         pixel_y_o,
  output logic [mco_pkg::ADDR_W-1:0]  pixel_addr_o,
  output logic [mco_pkg::COLOR_W-1:0] pixel_value_o,
  output logic                        pixel_valid_o,
  output logic                        in_bounds_o,
  output logic                        last_o,
  output logic                        finished_o
);

  localparam int PW   = ((COORD_BITS > RB + 1) ? COORD_BITS : RB + 1) + 2;
  localparam int CW   = (PW > mco_pkg::CANVAS_W + 1) ? PW : mco_pkg::CANVAS_W + 1;
  localparam int PY_W = mco_pkg::CANVAS_W + mco_pkg::PITCH_W;
  localparam int PX_W = mco_pkg::CANVAS_W + mco_pkg::PBYTES_W;
  localparam int CLR  = mco_pkg::COLOR_W;
  localparam logic signed [PW-1:0] ONE = PW'(1);

  // Job fields
  logic                  job_fin;
  logic [COORD_BITS-1:0] job_cx, job_cy;
  logic [CLR-1:0]        job_color;
  logic [RB-1:0]         job_x, job_y;

  assign job_fin   = job_i[JW-1];
  assign job_cx    = job_i[JW-2 -: COORD_BITS];
  assign job_cy    = job_i[JW-2-COORD_BITS -: COORD_BITS];
  assign job_color = job_i[2*RB +: CLR];
  assign job_x     = job_i[RB +: RB];
  assign job_y     = job_i[0 +: RB];

  logic en, issue;
  logic [2:0] idx_q, idx_d;

  // Whole pipeline moves unless the output holds an untaken result
  assign en        = ~out_valid_o | out_ready_i;
  assign issue     = en & job_valid_i;
  assign job_pop_o = issue & (job_fin | (idx_q == mco_pkg::OCT_LAST));

  // Step through the octants
  always_comb begin
    idx_d = idx_q;
    if (issue) begin
      idx_d = job_pop_o ? 3'd0 : idx_q + 3'd1;
    end
  end

  // Octant offsets
  logic signed [PW-1:0] x_ext, y_ext, cx_ext, cy_ext;
  logic signed [PW-1:0] t_a, t_b, t_c, t_d, tx, ty;

  assign x_ext  = $signed(PW'(job_x));
  assign y_ext  = $signed(PW'(job_y));
  assign cx_ext = PW'($signed(job_cx));
  assign cy_ext = PW'($signed(job_cy));
  assign t_a    = x_ext - ONE;
  assign t_b    = y_ext;
  assign t_c    = -x_ext;
  assign t_d    = -y_ext - ONE;

  always_comb begin
    case (idx_q)
      3'd0: begin tx = t_a; ty = t_b; end
      3'd1: begin tx = t_b; ty = t_a; end
      3'd2: begin tx = t_c; ty = t_b; end
      3'd3: begin tx = t_b; ty = t_c; end
      3'd4: begin tx = t_a; ty = t_d; end
      3'd5: begin tx = t_d; ty = t_a; end
      3'd6: begin tx = t_c; ty = t_d; end
      default: begin tx = t_d; ty = t_c; end
    endcase
  end

  // Keep the low colour bytes
  logic [CLR-1:0] value_mask;

  always_comb begin
    case (cfg_i.pixel_bytes)
      3'd0:    value_mask = '0;
      3'd1:    value_mask = {24'h0, job_color[7:0]};
      3'd2:    value_mask = {16'h0, job_color[15:0]};
      3'd3:    value_mask = {8'h0, job_color[23:0]};
      default: value_mask = job_color;
    endcase
  end

  // Stage one: coordinates
  logic                 s1_valid_q, s1_fin_q, s1_last_q;
  logic signed [PW-1:0] s1_px_q, s1_py_q;
  logic [CLR-1:0]       s1_value_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (job_fin) begin
        s1_fin_q   <= 1'b1;
        s1_last_q  <= 1'b1;
        s1_px_q    <= '0;
        s1_py_q    <= '0;
        s1_value_q <= '0;
      end else begin
        s1_fin_q   <= 1'b0;
        s1_last_q  <= (idx_q == mco_pkg::OCT_LAST);
        s1_px_q    <= cx_ext + tx;
        s1_py_q    <= cy_ext + ty;
        s1_value_q <= value_mask;
      end
    end
  end

  // Stage two: bounds and address products
  logic                 px_in, py_in;
  logic                 s2_valid_q, s2_fin_q, s2_last_q, s2_inb_q;
  logic [COORD_BITS:0]  s2_px_q, s2_py_q;
  logic [CLR-1:0]       s2_value_q;
  logic [PY_W-1:0]      s2_prod_y_q;
  logic [PX_W-1:0]      s2_prod_x_q;

  assign px_in = ~s1_px_q[PW-1] &&
                 ($unsigned(CW'(s1_px_q)) < CW'(cfg_i.canvas_width));
  assign py_in = ~s1_py_q[PW-1] &&
                 ($unsigned(CW'(s1_py_q)) < CW'(cfg_i.canvas_height));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_fin_q    <= s1_fin_q;
      s2_last_q   <= s1_last_q;
      s2_inb_q    <= ~s1_fin_q & px_in & py_in;
      s2_px_q     <= s1_px_q[COORD_BITS:0];
      s2_py_q     <= s1_py_q[COORD_BITS:0];
      s2_value_q  <= s1_value_q;
      s2_prod_y_q <= PY_W'(s1_py_q[mco_pkg::CANVAS_W-1:0]) * PY_W'(cfg_i.row_pitch);
      s2_prod_x_q <= PX_W'(s1_px_q[mco_pkg::CANVAS_W-1:0]) * PX_W'(cfg_i.pixel_bytes);
    end
  end

  // Stage three: address sum into the output register
  logic [PY_W-1:0] addr_sum;

  assign addr_sum = s2_prod_y_q + PY_W'(s2_prod_x_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pixel_x_o     <= s2_px_q;
      pixel_y_o     <= s2_py_q;
      pixel_addr_o  <= s2_inb_q ? addr_sum[mco_pkg::ADDR_W-1:0] : '0;
      pixel_value_o <= s2_value_q;
      pixel_valid_o <= ~s2_fin_q;
      in_bounds_o   <= s2_inb_q;
      last_o        <= s2_last_q;
      finished_o    <= s2_fin_q;
    end
  end

  // Valid bits and octant counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (en) begin
        s1_valid_q  <= job_valid_i;
        s2_valid_q  <= s1_valid_q;
        out_valid_o <= s2_valid_q;
      end
    end
  end

endmodule

[hw/rtl/midpoint_circle_outline.sv]
// Top level of the midpoint circle outline block: APB registers, front end, job queue, back end.
// Depends on mco_pkg, mco_front, mco_queue and mco_back.
//
// A start item (tuser 0) loads centre, radius and colour and gives no result.
// Each step item (tuser 1) gives eight pixel writes, one per cycle on the output port unless
// m_axis_tready stalls it; a step after the walk has ended gives one finished result.
// A result passes through the coordinate, bounds and address registers after its job
// reaches the back end; a queue of two jobs lets the input run ahead of the output.
// Radii above MAX_RADIUS are clamped. Registers (row pitch, pixel bytes, canvas width
// and height) sit at byte addresses 0, 4, 8 and 12 and may only be written while no
// results are outstanding.
module midpoint_circle_outline #(
  parameter int COORD_BITS = mco_pkg::COORD_BITS_DEF,
  parameter int MAX_RADIUS = mco_pkg::MAX_RADIUS_DEF,
  localparam int IN_DATA_W  =
    ((2 * COORD_BITS + mco_pkg::RADIUS_W + mco_pkg::COLOR_W + 7) / 8) * 8,
  localparam int OUT_DATA_W =
    ((2 * (COORD_BITS + 1) + mco_pkg::ADDR_W + mco_pkg::COLOR_W + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Request stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: center_x, center_y, radius, color (low bit up), zero fill
  input  logic [IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: req_type
  input  logic                       s_axis_tuser,
  // Pixel stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // tdata: pixel_x, pixel_y, pixel_addr, pixel_value (low bit up), zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: pixel_valid, in_bounds, finished (low bit up)
  output logic [mco_pkg::USER_W-1:0] m_axis_tuser,
  output logic                       m_axis_tlast
);

  localparam int RB = mco_pkg::radius_bits(MAX_RADIUS);
  localparam int JW = mco_pkg::job_width(COORD_BITS, RB);

  // Configuration registers
  mco_pkg::cfg_t cfg_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_pitch     <= mco_pkg::ROW_PITCH_RST;
      cfg_q.pixel_bytes   <= mco_pkg::PIXEL_BYTES_RST;
      cfg_q.canvas_width  <= mco_pkg::CANVAS_RST;
      cfg_q.canvas_height <= mco_pkg::CANVAS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mco_pkg::REG_ROW_PITCH:     cfg_q.row_pitch     <= pwdata[mco_pkg::PITCH_W-1:0];
        mco_pkg::REG_PIXEL_BYTES:   cfg_q.pixel_bytes   <= pwdata[mco_pkg::PBYTES_W-1:0];
        mco_pkg::REG_CANVAS_WIDTH:  cfg_q.canvas_width  <= pwdata[mco_pkg::CANVAS_W-1:0];
        mco_pkg::REG_CANVAS_HEIGHT: cfg_q.canvas_height <= pwdata[mco_pkg::CANVAS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (paddr[3:2])
      mco_pkg::REG_ROW_PITCH:     prdata = 32'(cfg_q.row_pitch);
      mco_pkg::REG_PIXEL_BYTES:   prdata = 32'(cfg_q.pixel_bytes);
      mco_pkg::REG_CANVAS_WIDTH:  prdata = 32'(cfg_q.canvas_width);
      mco_pkg::REG_CANVAS_HEIGHT: prdata = 32'(cfg_q.canvas_height);
      default:                    prdata = '0;
    endcase
  end

  // Unpack the request
  logic [COORD_BITS-1:0]        center_x, center_y;
  logic [mco_pkg::RADIUS_W-1:0] radius;
  logic [mco_pkg::COLOR_W-1:0]  color;

  assign center_x = s_axis_tdata[0 +: COORD_BITS];
  assign center_y = s_axis_tdata[COORD_BITS +: COORD_BITS];
  assign radius   = s_axis_tdata[2*COORD_BITS +: mco_pkg::RADIUS_W];
  assign color    = s_axis_tdata[2*COORD_BITS+mco_pkg::RADIUS_W +: mco_pkg::COLOR_W];

  // Front end
  logic          job_push, q_full, q_empty, job_pop;
  logic [JW-1:0] job_in, job_head;

  mco_front #(
    .COORD_BITS(COORD_BITS),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .center_x_i  (center_x),
    .center_y_i  (center_y),
    .radius_i    (radius),
    .color_i     (color),
    .job_valid_o (job_push),
    .job_ready_i (~q_full),
    .job_o       (job_in)
  );

  // Job queue
  mco_queue #(
    .WIDTH(JW),
    .DEPTH(mco_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (job_pop),
    .data_o  (job_head),
    .empty_o (q_empty)
  );

  // Back end
  logic [COORD_BITS:0]         pixel_x, pixel_y;
  logic [mco_pkg::ADDR_W-1:0]  pixel_addr;
  logic [mco_pkg::COLOR_W-1:0] pixel_value;
  logic                        pixel_valid, in_bounds, finished;

  mco_back #(
    .COORD_BITS(COORD_BITS),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (~q_empty),
    .job_i         (job_head),
    .job_pop_o     (job_pop),
    .cfg_i         (cfg_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_addr_o  (pixel_addr),
    .pixel_value_o (pixel_value),
    .pixel_valid_o (pixel_valid),
    .in_bounds_o   (in_bounds),
    .last_o        (m_axis_tlast),
    .finished_o    (finished)
  );

  // Pack the result
  assign m_axis_tdata = OUT_DATA_W'({pixel_value, pixel_addr, pixel_y, pixel_x});
  assign m_axis_tuser = {finished, in_bounds, pixel_valid};

endmodule

[hw/rtl/mco_checker.sv]
// Port-level checks on the pixel stream of midpoint_circle_outline, bound to the top level.
// Depends on mco_pkg.
module mco_checker #(
  parameter int COORD_BITS = mco_pkg::COORD_BITS_DEF,
  localparam int OUT_DATA_W =
    ((2 * (COORD_BITS + 1) + mco_pkg::ADDR_W + mco_pkg::COLOR_W + 7) / 8) * 8
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input logic [mco_pkg::USER_W-1:0] m_axis_tuser,
  input logic                       m_axis_tlast
);

  localparam int ADDR_LO = 2 * (COORD_BITS + 1);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pixel result changed while stalled");

  // A finished result closes its step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[mco_pkg::USER_FIN] |-> m_axis_tlast)
    else $error("finished result not marked last");

  // A finished result carries no pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[mco_pkg::USER_FIN] |->
      !m_axis_tuser[mco_pkg::USER_VALID] && !m_axis_tuser[mco_pkg::USER_INB] &&
      (m_axis_tdata == '0))
    else $error("finished result carries pixel data");

  // Drop the address of a pixel off the canvas
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[mco_pkg::USER_INB] |->
      (m_axis_tdata[ADDR_LO +: mco_pkg::ADDR_W] == '0))
    else $error("address given for pixel outside canvas");

endmodule

bind midpoint_circle_outline mco_checker #(
  .COORD_BITS(COORD_BITS)
) u_mco_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
